/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("check failed");
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");
`else
`define ASSERT_NEVER(lbl, cond)
`define ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

/* sv/doas_pkg.sv */
// ----------------------------------------------------------------------------
// doas_pkg
// Types, constants and helpers shared by the obstacle avoidance sequencer.
// ----------------------------------------------------------------------------
package doas_pkg;

	localparam int FRAME_ROWS = 480;
	localparam int FRAME_COLS = 640;
	localparam logic [9:0] ROW_LO = 10'(FRAME_ROWS * 3 / 10);
	localparam logic [9:0] ROW_HI = 10'(FRAME_ROWS * 7 / 10);
	localparam logic [9:0] COL_LO = 10'(FRAME_COLS * 3 / 10);
	localparam logic [9:0] COL_HI = 10'(FRAME_COLS * 7 / 10);

	localparam logic [17:0] NO_OBSTACLE_MM = 18'd200000;
	localparam logic [15:0] MIN_VALID_MM   = 16'd200;
	localparam logic [31:0] MISSION_UM     = 32'd300000000;

	localparam logic [2:0] MODE_CRUISE  = 3'd0;
	localparam logic [2:0] MODE_STRAFE  = 3'd1;
	localparam logic [2:0] MODE_EXTRA   = 3'd2;
	localparam logic [2:0] MODE_FWD_CLR = 3'd3;
	localparam logic [2:0] MODE_RETURN  = 3'd4;

	localparam logic [2:0] REG_DETECT   = 3'd0;
	localparam logic [2:0] REG_CLEAR    = 3'd1;
	localparam logic [2:0] REG_EXTRA    = 3'd2;
	localparam logic [2:0] REG_FWD_CLR  = 3'd3;
	localparam logic [2:0] REG_RETURN   = 3'd4;
	localparam logic [2:0] REG_STRAFE_V = 3'd5;
	localparam logic [2:0] REG_FWD_V    = 3'd6;
	localparam logic [2:0] REG_CRUISE_V = 3'd7;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic        action;
		logic [15:0] depth_mm;
		logic [9:0]  pixel_row;
		logic [9:0]  pixel_col;
		logic        frame_last;
		logic [15:0] dt_ms;
		logic        depth_fresh;
	} item_t;

	typedef struct packed {
		logic signed [12:0] vel_x_mm_s;
		logic [11:0] vel_y_mm_s;
		logic [2:0]  avoid_mode;
		logic [17:0] obstacle_mm;
		logic [31:0] lateral_offset_um;
		logic [31:0] forward_progress_um;
		logic        mission_done;
		logic        halted;
	} result_t;

	// control tick as queued between front and back
	typedef struct packed {
		logic [15:0] dt_ms;
		logic        fresh;
		logic        seen;
		logic [17:0] frame_min;
	} tick_t;

	typedef struct packed {
		logic [15:0] detect;
		logic [15:0] clear;
		logic [15:0] extra;
		logic [15:0] fwd_clr;
		logic [15:0] ret;
		logic [11:0] strafe_v;
		logic [11:0] fwd_v;
		logic [11:0] cruise_v;
	} cfg_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [27:0] p);
		logic [32:0] s;
		s = {1'b0, a} + 33'(p);
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

/* sv/depth_obstacle_avoid_sequencer.sv */
// ----------------------------------------------------------------------------
// depth_obstacle_avoid_sequencer
// Depth window minimum per frame and a five-mode avoidance sequencer.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | word
//  ---------+---------------------------+-----------------------------
//  item     | item_valid / item_stall   | item   (pixel or control tick)
//  result   | result_valid/result_stall | result (one per tick)
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  Pixels: one word per cycle unless stalled, folded in on accept, no result.
//  Ticks: queued (4 deep); the back end takes one tick at a time, first the
//  products (registered at the pop), then the update into the result
//  register, and pops no new tick until that is done and the output is free.
//  Item stall rises only when the tick queue is full; result stall holds
//  the output register and, once the queue fills, the input side.
//  Reset: config to defaults, cruise mode, no frame seen, sums cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module depth_obstacle_avoid_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  doas_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output doas_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import doas_pkg::*;

	cfg_t  cfg_q;
	tick_t push_tick, q_tick;
	logic  push, pop, q_full, q_empty, accept;

	// registers are always writable; caller keeps to idle periods
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detect   <= 16'd3000;
			cfg_q.clear    <= 16'd5000;
			cfg_q.extra    <= 16'd1000;
			cfg_q.fwd_clr  <= 16'd4000;
			cfg_q.ret      <= 16'd4000;
			cfg_q.strafe_v <= 12'd600;
			cfg_q.fwd_v    <= 12'd800;
			cfg_q.cruise_v <= 12'd1000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DETECT:   cfg_q.detect   <= cfg_data;
				REG_CLEAR:    cfg_q.clear    <= cfg_data;
				REG_EXTRA:    cfg_q.extra    <= cfg_data;
				REG_FWD_CLR:  cfg_q.fwd_clr  <= cfg_data;
				REG_RETURN:   cfg_q.ret      <= cfg_data;
				REG_STRAFE_V: cfg_q.strafe_v <= cfg_data[11:0];
				REG_FWD_V:    cfg_q.fwd_v    <= cfg_data[11:0];
				REG_CRUISE_V: cfg_q.cruise_v <= cfg_data[11:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	// front: accepts every word unless the tick queue is full
	assign item_stall = q_full;
	assign accept     = item_valid && !item_stall;

	doas_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.push   (push),
		.tick   (push_tick)
	);

	doas_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_tick (push_tick),
		.pop     (pop),
		.rd_tick (q_tick),
		.full    (q_full),
		.empty   (q_empty)
	);

	doas_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_tick       (q_tick),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	`ASSERT_NEVER(a_no_overflow, push && q_full)
	`ASSERT_NEVER(a_no_underflow, pop && q_empty)
	`ASSERT_IMPL(a_halt_zero, result_valid && result.halted, result.vel_x_mm_s == 13'sd0 && result.vel_y_mm_s == 12'd0)
	`ASSERT_IMPL(a_done_zero, result_valid && result.mission_done, result.vel_x_mm_s == 13'sd0 && result.vel_y_mm_s == 12'd0)
endmodule

/* sv/doas_queue.sv */
// ----------------------------------------------------------------------------
// doas_queue
// Short queue of control ticks between front and back.
// ----------------------------------------------------------------------------
module doas_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  doas_pkg::tick_t wr_tick,
	input  logic           pop,
	output doas_pkg::tick_t rd_tick,
	output logic           full,
	output logic           empty
);
	import doas_pkg::*;

	tick_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]    count_q;

	assign full    = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_tick = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

/* sv/doas_front.sv */
// ----------------------------------------------------------------------------
// doas_front
// Takes words in, folds pixels into the window minimum, queues ticks.
// ----------------------------------------------------------------------------
module doas_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  doas_pkg::item_t item,
	output logic            push,
	output doas_pkg::tick_t tick
);
	import doas_pkg::*;

	logic [17:0] window_min_q, frame_min_q;
	logic        frame_seen_q;
	logic        in_win;
	logic [17:0] win_next;

	assign in_win = (item.pixel_row >= ROW_LO) && (item.pixel_row < ROW_HI) &&
			(item.pixel_col >= COL_LO) && (item.pixel_col < COL_HI);

	always_comb begin
		win_next = window_min_q;
		if (in_win && item.depth_mm > MIN_VALID_MM && 18'(item.depth_mm) < window_min_q) begin
			win_next = 18'(item.depth_mm);
		end
	end

	// state snapshot travels with the tick so later pixels cannot overtake it
	assign push           = accept && item.action;
	assign tick.dt_ms     = item.dt_ms;
	assign tick.fresh     = item.depth_fresh;
	assign tick.seen      = frame_seen_q;
	assign tick.frame_min = frame_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_min_q <= NO_OBSTACLE_MM;
			frame_min_q  <= NO_OBSTACLE_MM;
			frame_seen_q <= 1'b0;
		end else if (accept && !item.action) begin
			if (item.frame_last) begin
				frame_min_q  <= win_next;
				frame_seen_q <= 1'b1;
				window_min_q <= NO_OBSTACLE_MM;
			end else begin
				window_min_q <= win_next;
			end
		end
	end
endmodule

/* sv/doas_back.sv */
// ----------------------------------------------------------------------------
// doas_back
// Runs the avoidance modes per tick: products registered at pop, then update.
// ----------------------------------------------------------------------------
module doas_back (
	input  logic              clk,
	input  logic              arst_n,
	input  doas_pkg::cfg_t    cfg,
	input  logic              q_empty,
	input  doas_pkg::tick_t   q_tick,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output doas_pkg::result_t result
);
	import doas_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic        state_q;
	tick_t       tick_s1;
	logic [27:0] p_off_s1, p_fwd_s1, p_trav_s1;
	logic [11:0] vy_s1;
	logic [2:0]  mode_q;
	logic [31:0] offset_q, forward_q, travel_q;
	logic        out_free;
	logic [11:0] vy_sel;
	logic        halted_now;

	logic [2:0]  mode_n;
	logic [31:0] off_n, fwd_n, trav_n, off_sum;
	logic [11:0] vx_mag;
	logic        vx_neg, mission;
	result_t     res_n;

	assign out_free = !result_valid || !result_stall;
	assign pop      = (state_q == ST_IDLE) && !q_empty && out_free;

	// forward speed is fixed by the mode at entry (in cruise also by the detect check)
	always_comb begin
		unique case (mode_q)
			MODE_CRUISE:  vy_sel = (q_tick.frame_min < 18'(cfg.detect)) ? 12'd0 : cfg.cruise_v;
			MODE_FWD_CLR: vy_sel = cfg.fwd_v;
			MODE_RETURN:  vy_sel = cfg.fwd_v >> 1;
			default:      vy_sel = 12'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tick_s1   <= q_tick;
			p_off_s1  <= 28'(cfg.strafe_v) * 28'(q_tick.dt_ms);
			p_fwd_s1  <= 28'(cfg.fwd_v) * 28'(q_tick.dt_ms);
			p_trav_s1 <= 28'(vy_sel) * 28'(q_tick.dt_ms);
			vy_s1     <= vy_sel;
		end
	end

	assign halted_now = !tick_s1.seen || !tick_s1.fresh;
	assign off_sum    = sat_add(offset_q, p_off_s1);

	always_comb begin
		mode_n = mode_q;
		off_n  = offset_q;
		fwd_n  = forward_q;
		trav_n = travel_q;
		vx_mag = 12'd0;
		vx_neg = 1'b0;
		if (!halted_now) begin
			unique case (mode_q)
				MODE_CRUISE: begin
					if (tick_s1.frame_min < 18'(cfg.detect)) begin
						off_n  = '0;
						mode_n = MODE_STRAFE;
					end
				end
				MODE_STRAFE: begin
					vx_mag = cfg.strafe_v;
					off_n  = off_sum;
					if (tick_s1.frame_min > 18'(cfg.clear)) begin
						off_n  = '0;
						mode_n = MODE_EXTRA;
					end
				end
				MODE_EXTRA: begin
					vx_mag = cfg.strafe_v;
					off_n  = off_sum;
					if (off_sum >= 32'(cfg.extra * 26'd1000)) begin
						fwd_n  = '0;
						mode_n = MODE_FWD_CLR;
					end
				end
				MODE_FWD_CLR: begin
					fwd_n = sat_add(forward_q, p_fwd_s1);
					if (fwd_n >= 32'(cfg.fwd_clr * 26'd1000)) begin
						off_n  = '0;
						mode_n = MODE_RETURN;
					end
				end
				MODE_RETURN: begin
					vx_mag = cfg.strafe_v;
					vx_neg = 1'b1;
					off_n  = off_sum;
					if (off_sum >= 32'(cfg.ret * 26'd1000)) begin
						off_n  = '0;
						mode_n = MODE_CRUISE;
					end
				end
				default: mode_n = MODE_CRUISE;
			endcase
			trav_n = sat_add(travel_q, p_trav_s1);
		end
		mission = (trav_n >= MISSION_UM);

		res_n.vel_x_mm_s          = vx_neg ? -$signed({1'b0, vx_mag}) : $signed({1'b0, vx_mag});
		res_n.vel_y_mm_s          = vy_s1;
		if (halted_now || mission) begin
			res_n.vel_x_mm_s = '0;
			res_n.vel_y_mm_s = '0;
		end
		res_n.avoid_mode          = mode_n;
		res_n.obstacle_mm         = tick_s1.frame_min;
		res_n.lateral_offset_um   = off_n;
		res_n.forward_progress_um = fwd_n;
		res_n.mission_done        = mission;
		res_n.halted              = halted_now;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			result <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result_valid <= 1'b0;
			mode_q       <= MODE_CRUISE;
			offset_q     <= '0;
			forward_q    <= '0;
			travel_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
					if (result_valid && !result_stall) begin
						result_valid <= 1'b0;
					end
				end
				ST_EXEC: begin
					state_q      <= ST_IDLE;
					result_valid <= 1'b1;
					mode_q       <= mode_n;
					offset_q     <= off_n;
					forward_q    <= fwd_n;
					travel_q     <= trav_n;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
